// File: hw/rtl/klc_pkg.sv
`timescale 1ns / 1ps

package klc_pkg;

    // field widths
    localparam int KEY_W  = 32;
    localparam int LINK_W = 32;
    localparam int CNT_W  = 31;
    localparam int CAP_W  = 5;

    // saturation value of the hit and miss counts
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // contents of one cell of the sorted row
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
    } t_entry;

    // request broadcast to every cell
    typedef struct packed {
        logic              update;
        logic              evict;
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
    } t_bcast;

endpackage

// File: hw/rtl/klc_cell.sv
`timescale 1ns / 1ps

module klc_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  klc_pkg::t_bcast i_bcast,
    input  klc_pkg::t_entry i_left,
    input  logic            i_left_lt,
    input  klc_pkg::t_entry i_right,
    input  logic            i_right_lt,
    output klc_pkg::t_entry o_entry,
    output logic            o_lt,
    output logic            o_match
);
    import klc_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [LINK_W-1:0] r_link;
    logic              n_valid;
    logic [KEY_W-1:0]  n_key;
    logic [LINK_W-1:0] n_link;

    // compare against the broadcast key
    assign o_lt    = r_valid && (r_key < i_bcast.key);
    assign o_match = r_valid && (r_key == i_bcast.key);

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.link  = r_link;

    // shift-insert: on eviction the row moves down by one, else up from the gap
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_link  = r_link;
        if (i_bcast.update) begin
            if (i_bcast.evict) begin
                if (i_right_lt) begin
                    n_key  = i_right.key;
                    n_link = i_right.link;
                end else if (FIRST || o_lt) begin
                    n_key  = i_bcast.key;
                    n_link = i_bcast.link;
                end
            end else if (!o_lt) begin
                if (FIRST || i_left_lt) begin
                    n_valid = 1'b1;
                    n_key   = i_bcast.key;
                    n_link  = i_bcast.link;
                end else begin
                    n_valid = i_left.valid;
                    n_key   = i_left.key;
                    n_link  = i_left.link;
                end
            end
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key and link payload
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_link <= n_link;
    end

endmodule

// File: hw/rtl/key_link_cache_min_key_evict.sv
`timescale 1ns / 1ps

// Fully associative key-to-link cache with smallest-key eviction. A request is
// taken when start is high and busy is low; busy is then high for one cycle
// while the key is compared in every cell at once and, on a miss, the new pair
// is shift-inserted into the row of cells kept sorted by key. The result is on
// the o_ ports for exactly one cycle, marked by o_done, in the cycle in which
// busy falls; it cannot be held off, so the receiver must take it then.
// A request goes from the capture register to the cell row, and no new one
// is taken while busy is high. The capacity register must be written with
// i_cfg_we only while no request is in flight; the block does not enforce
// this. Zero acts as one and values above ENTRIES act as ENTRIES.
module key_link_cache_min_key_evict #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [klc_pkg::KEY_W-1:0]  i_dest_key,
    input  logic [klc_pkg::LINK_W-1:0] i_backing_link,
    input  logic                       i_cfg_we,
    input  logic [klc_pkg::CAP_W-1:0]  i_cfg_data,
    output logic                       o_done,
    output logic [klc_pkg::LINK_W-1:0] o_link_value,
    output logic                       o_was_hit,
    output logic [klc_pkg::CNT_W-1:0]  o_hits_so_far,
    output logic [klc_pkg::CNT_W-1:0]  o_misses_so_far
);
    import klc_pkg::*;

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam logic [CMP_W-1:0] CMP_ENTRIES = CMP_W'(ENTRIES);
    localparam logic [CMP_W-1:0] CMP_ONE     = CMP_W'(1);
    localparam logic [FILL_W-1:0] FILL_ONE   = FILL_W'(1);

    logic [CAP_W-1:0]  r_cap;
    logic              r_busy;
    logic [KEY_W-1:0]  r_key;
    logic [LINK_W-1:0] r_link;
    logic [FILL_W-1:0] r_fill;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;
    logic              r_done;
    logic [LINK_W-1:0] r_out_link;
    logic              r_out_hit;

    t_bcast            w_bcast;
    t_entry            w_entry [ENTRIES];
    logic              w_lt    [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_valid;
    logic              w_hit;
    logic [LINK_W-1:0] w_hit_link;
    logic [CMP_W-1:0]  w_cap_ext;
    logic [CMP_W-1:0]  w_cap_eff;
    logic              w_evict;
    logic [CNT_W-1:0]  n_hits;
    logic [CNT_W-1:0]  n_misses;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_key  <= i_dest_key;
            r_link <= i_backing_link;
        end
    end

    assign busy = r_busy;

    // effective capacity and eviction decision
    assign w_cap_ext = CMP_W'(r_cap);
    always_comb begin
        priority if (w_cap_ext == '0) begin
            w_cap_eff = CMP_ONE;
        end else if (w_cap_ext > CMP_ENTRIES) begin
            w_cap_eff = CMP_ENTRIES;
        end else begin
            w_cap_eff = w_cap_ext;
        end
    end
    assign w_evict = CMP_W'(r_fill) >= w_cap_eff;

    // broadcast to the row
    assign w_bcast.update = r_busy && !w_hit;
    assign w_bcast.evict  = w_evict;
    assign w_bcast.key    = r_key;
    assign w_bcast.link   = r_link;

    // row of cells, sorted by key from cell 0 upwards
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_lt;
        logic   w_right_lt;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_lt = 1'b0;
        end else begin : g_mid_l
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign w_right    = '0;
            assign w_right_lt = 1'b0;
        end else begin : g_mid_r
            assign w_right    = w_entry[g+1];
            assign w_right_lt = w_lt[g+1];
        end

        klc_cell #(
            .FIRST(g == 0)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_bcast   (w_bcast),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .i_right_lt(w_right_lt),
            .o_entry   (w_entry[g]),
            .o_lt      (w_lt[g]),
            .o_match   (w_match[g])
        );

        assign w_valid[g] = w_entry[g].valid;
    end

    // hit detection and link selection, at most one cell matches
    assign w_hit = |w_match;
    always_comb begin
        w_hit_link = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_link = w_hit_link | ({LINK_W{w_match[i]}} & w_entry[i].link);
        end
    end

    // fill count, grows only on a miss with no eviction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (r_busy && !w_hit && !w_evict) begin
            r_fill <= r_fill + FILL_ONE;
        end
    end

    // saturating counts
    assign n_hits   = (r_hits == CNT_MAX) ? r_hits : r_hits + CNT_W'(1);
    assign n_misses = (r_misses == CNT_MAX) ? r_misses : r_misses + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (r_busy) begin
            if (w_hit) begin
                r_hits <= n_hits;
            end else begin
                r_misses <= n_misses;
            end
        end
    end

    // result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_hit  <= w_hit;
            r_out_link <= w_hit ? w_hit_link : r_link;
        end
    end

    assign o_done          = r_done;
    assign o_link_value    = r_out_link;
    assign o_was_hit       = r_out_hit;
    assign o_hits_so_far   = r_hits;
    assign o_misses_so_far = r_misses;

    // checks
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken into the cell row");

    a_done_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("result strobe missing after compare cycle");

    a_done_only_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request");

    a_fill_matches_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid) == int'(r_fill)))
        else $error("fill count out of step with valid cells");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $onehot0(w_match))
        else $error("key stored in more than one cell");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import klc_pkg::*;

    localparam int NUM_CELLS   = 16;
    localparam int RANDOM_REQS = 600;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 200000;

    // one pending stimulus step: a lookup or a capacity write
    typedef struct {
        bit                is_cap_write;
        logic [CAP_W-1:0]  cap;
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
    } t_request;

    // predicted outcome of one lookup transaction
    typedef struct {
        logic [LINK_W-1:0] link;
        logic              hit;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } t_lookup;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KEY_W-1:0]  i_dest_key = '0;
    logic [LINK_W-1:0] i_backing_link = '0;
    logic              i_cfg_we = 1'b0;
    logic [CAP_W-1:0]  i_cfg_data = '0;
    logic              o_done;
    logic [LINK_W-1:0] o_link_value;
    logic              o_was_hit;
    logic [CNT_W-1:0]  o_hits_so_far;
    logic [CNT_W-1:0]  o_misses_so_far;

    key_link_cache_min_key_evict #(
        .ENTRIES(NUM_CELLS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_dest_key     (i_dest_key),
        .i_backing_link (i_backing_link),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_link_value   (o_link_value),
        .o_was_hit      (o_was_hit),
        .o_hits_so_far  (o_hits_so_far),
        .o_misses_so_far(o_misses_so_far)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_request request_q[$];
    t_lookup  lookup_q[$];
    int       sent_cnt = 0;
    int       done_cnt = 0;
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;

    // shadow copy of the cache contents
    logic [KEY_W-1:0]  cell_key[NUM_CELLS];
    logic [LINK_W-1:0] cell_link[NUM_CELLS];
    logic              cell_valid[NUM_CELLS];
    logic [CNT_W-1:0]  hit_tally = '0;
    logic [CNT_W-1:0]  miss_tally = '0;
    logic [CAP_W-1:0]  cache_cap = CAP_RESET;

    initial begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            cell_valid[i] = 1'b0;
        end
    end

    // look the key up in the shadow table and update it as the block should
    function automatic t_lookup cache_lookup(input logic [KEY_W-1:0] key,
                                             input logic [LINK_W-1:0] link);
        t_lookup res;
        int fill;
        int hit_at;
        int min_at;
        int free_at;
        int slot;
        int limit;
        fill    = 0;
        hit_at  = -1;
        min_at  = -1;
        free_at = -1;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (cell_valid[i]) begin
                fill++;
                if (cell_key[i] == key) hit_at = i;
                if (min_at < 0 || cell_key[i] < cell_key[min_at]) min_at = i;
            end else if (free_at < 0) begin
                free_at = i;
            end
        end
        // zero acts as one, anything above the table size as the table size
        limit = int'(cache_cap);
        if (limit == 0) limit = 1;
        if (limit > NUM_CELLS) limit = NUM_CELLS;
        if (hit_at >= 0) begin
            if (hit_tally != CNT_MAX) hit_tally = hit_tally + 1'b1;
            res.link = cell_link[hit_at];
            res.hit  = 1'b1;
        end else begin
            slot = free_at;
            if (fill >= limit && min_at >= 0) begin
                cell_valid[min_at] = 1'b0;
                slot = min_at;
            end
            if (slot >= 0) begin
                cell_key[slot]   = key;
                cell_link[slot]  = link;
                cell_valid[slot] = 1'b1;
            end
            if (miss_tally != CNT_MAX) miss_tally = miss_tally + 1'b1;
            res.link = link;
            res.hit  = 1'b0;
        end
        res.hits   = hit_tally;
        res.misses = miss_tally;
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic queue_lookup(input logic [KEY_W-1:0] key,
                                input logic [LINK_W-1:0] link);
        t_request r;
        r.is_cap_write = 1'b0;
        r.cap          = '0;
        r.key          = key;
        r.link         = link;
        request_q.insert(request_q.size(), r);
    endtask

    task automatic queue_cap_write(input logic [CAP_W-1:0] cap);
        t_request r;
        r.is_cap_write = 1'b1;
        r.cap          = cap;
        r.key          = '0;
        r.link         = '0;
        request_q.insert(request_q.size(), r);
    endtask

    // driver: bursts of requests with random gaps, capacity writes only when idle
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin : driver
        t_request req;
        logic     took;
        logic     next_start;
        logic     next_we;
        if (i_rst_n) begin
            took       = start && !busy;
            next_start = start && !took;
            next_we    = 1'b0;
            if (took) begin
                lookup_q.insert(lookup_q.size(), cache_lookup(i_dest_key, i_backing_link));
                sent_cnt <= sent_cnt + 1;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() != 0) begin
                    req = request_q[0];
                    if (req.is_cap_write) begin
                        // nothing in flight and every result back
                        if (!took && sent_cnt == done_cnt) begin
                            void'(request_q.pop_front());
                            next_we    = 1'b1;
                            i_cfg_data <= req.cap;
                            cache_cap  = req.cap;
                        end
                    end else begin
                        void'(request_q.pop_front());
                        i_dest_key     <= req.key;
                        i_backing_link <= req.link;
                        next_start     = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 20);
                            case ($urandom_range(0, 9))
                                0, 1, 2, 3: gap_left = 0;
                                9:          gap_left = $urandom_range(8, 20);
                                default:    gap_left = $urandom_range(1, 5);
                            endcase
                        end
                    end
                end
            end
            start    <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // monitor: every result strobe is checked against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_lookup want;
        if (i_rst_n && o_done) begin
            done_cnt <= done_cnt + 1;
            if (lookup_q.size() == 0) begin
                flag_mismatch("result with no transaction outstanding");
            end else begin
                want = lookup_q.pop_front();
                if (o_link_value !== want.link)
                    flag_mismatch($sformatf("link_value %h, expected %h",
                                            o_link_value, want.link));
                if (o_was_hit !== want.hit)
                    flag_mismatch($sformatf("was_hit %b, expected %b",
                                            o_was_hit, want.hit));
                if (o_hits_so_far !== want.hits)
                    flag_mismatch($sformatf("hits_so_far %0d, expected %0d",
                                            o_hits_so_far, want.hits));
                if (o_misses_so_far !== want.misses)
                    flag_mismatch($sformatf("misses_so_far %0d, expected %0d",
                                            o_misses_so_far, want.misses));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus and end of run
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    initial begin : stimulus
        logic [KEY_W-1:0] key;
        int               left;
        int               phase_len;
        int               roll;

        // small capacity from an empty table, zero acting as one
        queue_cap_write('0);
        queue_lookup(32'd5, 32'hA5A5_0005);
        queue_lookup(32'd5, 32'h1111_1111);
        queue_lookup(32'd3, 32'h5A5A_0003);
        queue_lookup(32'd5, 32'h0000_0055);
        queue_lookup(32'd3, 32'h0000_0033);
        // capacity of three with the extreme keys and links
        queue_cap_write(5'd3);
        queue_lookup('0, '0);
        queue_lookup('1, '1);
        queue_lookup('0, 32'h1234_5678);
        queue_lookup(32'd7, 32'hFFFF_0000);
        queue_lookup('1, '0);
        queue_lookup('0, 32'h0000_FFFF);
        // capacity above the table size fills every cell
        queue_cap_write('1);
        for (int i = 0; i < 13; i++) begin
            queue_lookup(32'h100 + i, $urandom);
        end
        // capacity lowered below the fill: one eviction per miss
        queue_cap_write(5'd1);
        queue_lookup(32'h200, 32'hDEAD_BEEF);
        queue_lookup(32'h200, 32'h0BAD_F00D);

        // key pool so that random lookups hit often
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = (i < 6) ? KEY_W'($urandom_range(0, 40)) : $urandom;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        left = RANDOM_REQS;
        while (left > 0) begin
            case ($urandom_range(0, 6))
                0:       queue_cap_write('0);
                1:       queue_cap_write(5'd1);
                2:       queue_cap_write(5'd16);
                3:       queue_cap_write('1);
                4:       queue_cap_write(5'd17);
                default: queue_cap_write(CAP_W'($urandom_range(0, 31)));
            endcase
            // refresh a few pool keys so new keys keep arriving
            for (int i = 0; i < 4; i++) begin
                key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
            end
            phase_len = $urandom_range(40, 120);
            if (phase_len > left) phase_len = left;
            for (int i = 0; i < phase_len; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (roll < 80)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)]
                          ^ (32'h1 << $urandom_range(0, 31));
                else
                    key = $urandom;
                queue_lookup(key, $urandom);
            end
            left -= phase_len;
        end
        // back to the reset capacity for the tail
        queue_cap_write(CAP_RESET);
        for (int i = 0; i < 8; i++) begin
            queue_lookup(key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
        end

        // reset once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then allow for a late stray strobe
        while (request_q.size() != 0 || start || sent_cnt != done_cnt) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        if (lookup_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", lookup_q.size()));
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
